>>> sv/rgba_unpremultiply_defines.svh
// Assertion macros shared by the rgba_unpremultiply RTL.
// Include by bare file name; expects clk_i and rst_ni in scope.
`ifndef RGBA_UNPREMULTIPLY_DEFINES_SVH
`define RGBA_UNPREMULTIPLY_DEFINES_SVH

// Check on every rising edge outside reset.
`define RUP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising edge, also while reset is held.
`define RUP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/rup_pkg.sv
`timescale 1ns / 1ps
// Constants and the channel scaling function for rgba_unpremultiply.
// No dependencies.
package rup_pkg;

  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned SCALE_W      = 16;
  localparam int unsigned PROD_W       = CHAN_W + SCALE_W;
  localparam int unsigned ALPHA_LEVELS = 1 << CHAN_W;
  localparam int unsigned FULL_SCALE   = 255 * 256;
  localparam int unsigned ROUND_HALF   = 128;
  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;

  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;
  localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

  // Register index codes
  localparam logic [0:0] REG_SRC_PREMULT = 1'b0;

  // Scale one colour byte by the reciprocal, round and saturate.
  function automatic logic [CHAN_W-1:0] chan_scale(input logic [CHAN_W-1:0]  c,
                                                   input logic [SCALE_W-1:0] s);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rnd;
    logic [PROD_W-1:0] shifted;
    prod    = PROD_W'(c) * PROD_W'(s);
    rnd     = prod + PROD_W'(ROUND_HALF);
    shifted = rnd >> FRAC_BITS;
    if (shifted > PROD_W'(CHAN_MAX)) begin
      chan_scale = CHAN_MAX;
    end else begin
      chan_scale = shifted[CHAN_W-1:0];
    end
  endfunction

endpackage

>>> sv/rgba_unpremultiply.sv
`timescale 1ns / 1ps
// Top level of the RGBA unpremultiply pipeline with its APB mode register.
// Depends on rup_pkg and rgba_unpremultiply_defines.svh.
//
//  channel  signals                               direction  width
//  -------  ------------------------------------  ---------  ---------------
//  in       in_valid_i/in_ready_o, r/g/b/a _in_i   sink       4 x 8 bits
//  out      out_valid_o/out_ready_i, r/g/b/a _out_o source    4 x 8 bits
//  apb      psel/penable/pwrite/paddr/pwdata/prdata  slave    32-bit data
//
// One pixel per clock sustained while out_ready_i stays high; a result passes the stage 1 and
// stage 2 registers before out_valid_o rises and its transaction can complete.
// Stage 1 reads the reciprocal ROM (256 x 16, registered read) addressed by alpha.
// Stage 2 holds three 8x16 multipliers, rounding and saturation, then the output register.
// Reset empties both stages and sets source_premultiplied to 1; no clearing pass.
// A stall at the output holds stage 2; stage 1 still fills, then input ready drops.
`include "rgba_unpremultiply_defines.svh"

module rgba_unpremultiply (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rup_pkg::CHAN_W-1:0]       red_in_i,
  input  logic [rup_pkg::CHAN_W-1:0]       green_in_i,
  input  logic [rup_pkg::CHAN_W-1:0]       blue_in_i,
  input  logic [rup_pkg::CHAN_W-1:0]       alpha_in_i,
  // pixel output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rup_pkg::CHAN_W-1:0]       red_out_o,
  output logic [rup_pkg::CHAN_W-1:0]       green_out_o,
  output logic [rup_pkg::CHAN_W-1:0]       blue_out_o,
  output logic [rup_pkg::CHAN_W-1:0]       alpha_out_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rup_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rup_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rup_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int unsigned ScaleW = rup_pkg::SCALE_W;
  localparam int unsigned ChanW  = rup_pkg::CHAN_W;

  // ---------------------------------------------------------------------------
  // Mode register
  // ---------------------------------------------------------------------------
  logic       premult_q, premult_d;
  logic [0:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rup_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    premult_d = premult_q;
    if (cfg_wr && (reg_idx == rup_pkg::REG_SRC_PREMULT)) begin
      premult_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      premult_q <= 1'b1;
    end else begin
      premult_q <= premult_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == rup_pkg::REG_SRC_PREMULT) begin
      prdata[0] = premult_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Reciprocal ROM: entry a holds floor(65280 / a), entry 0 unused
  // ---------------------------------------------------------------------------
  logic [ScaleW-1:0] scale_rom [rup_pkg::ALPHA_LEVELS];

  for (genvar g = 0; g < rup_pkg::ALPHA_LEVELS; g++) begin : g_rom
    localparam int unsigned Div = (g == 0) ? 1 : g;
    localparam int unsigned Val = (g == 0) ? 0 : (rup_pkg::FULL_SCALE / Div);
    assign scale_rom[g] = ScaleW'(Val);
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic in_acc, s2_load;

  assign out_valid_o = s2_valid_q;
  assign s2_load     = s1_valid_q && (!s2_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s2_load;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s2_valid_d = s2_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    if (s2_load) begin
      s2_valid_d = 1'b1;
    end else if (out_ready_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture pixel and mode, registered ROM read
  // ---------------------------------------------------------------------------
  logic [ChanW-1:0]  s1_red_q, s1_green_q, s1_blue_q, s1_alpha_q;
  logic [ScaleW-1:0] s1_scale_q;
  logic              s1_premult_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_red_q     <= red_in_i;
      s1_green_q   <= green_in_i;
      s1_blue_q    <= blue_in_i;
      s1_alpha_q   <= alpha_in_i;
      s1_premult_q <= premult_q;
      s1_scale_q   <= scale_rom[alpha_in_i];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale, round, saturate, select special cases
  // ---------------------------------------------------------------------------
  logic [ChanW-1:0] red_d, green_d, blue_d, alpha_d;
  logic [ChanW-1:0] red_q, green_q, blue_q, alpha_q;

  always_comb begin
    alpha_d = s1_alpha_q;
    red_d   = s1_red_q;
    green_d = s1_green_q;
    blue_d  = s1_blue_q;
    if (s1_premult_q) begin
      if (s1_alpha_q == rup_pkg::CHAN_ZERO) begin
        red_d   = rup_pkg::CHAN_ZERO;
        green_d = rup_pkg::CHAN_ZERO;
        blue_d  = rup_pkg::CHAN_ZERO;
      end else if (s1_alpha_q != rup_pkg::CHAN_MAX) begin
        red_d   = rup_pkg::chan_scale(s1_red_q, s1_scale_q);
        green_d = rup_pkg::chan_scale(s1_green_q, s1_scale_q);
        blue_d  = rup_pkg::chan_scale(s1_blue_q, s1_scale_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
    end
  end

  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign alpha_out_o = alpha_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic conv_zero, conv_mid, scale_ok, rgb_zero, s2_pass;

  assign conv_zero = s1_premult_q && (s1_alpha_q == rup_pkg::CHAN_ZERO);
  assign conv_mid  = s1_premult_q && (s1_alpha_q != rup_pkg::CHAN_ZERO) &&
                     (s1_alpha_q != rup_pkg::CHAN_MAX);
  assign scale_ok  = (s1_scale_q > ScaleW'(256)) &&
                     (s1_scale_q <= ScaleW'(rup_pkg::FULL_SCALE));
  assign rgb_zero  = (red_q == rup_pkg::CHAN_ZERO) && (green_q == rup_pkg::CHAN_ZERO) &&
                     (blue_q == rup_pkg::CHAN_ZERO);
  assign s2_pass   = s2_load && !s1_premult_q;

  `RUP_ASSERT(a_accept_fills_s1, in_acc |=> s1_valid_q, "accepted pixel lost in stage 1")
  `RUP_ASSERT(a_scale_range, s1_valid_q && conv_mid |-> scale_ok, "reciprocal out of range")
  `RUP_ASSERT(a_zero_alpha, s2_load && conv_zero |=> rgb_zero, "zero alpha pixel not cleared")
  `RUP_ASSERT(a_pass_through, s2_pass |=> red_q == $past(s1_red_q), "pass-through altered")
  `RUP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !s1_valid_q && !s2_valid_q, "not empty in reset")

endmodule
